// File: hdl/btf_pkg.sv
// Shared types and constants for the block transaction framer.
package btf_pkg;

	localparam int TX_W            = 23;
	localparam int POS_W           = TX_W + 1;
	localparam int MAX_BLOCK_BYTES = 2 ** TX_W;
	localparam int HEADER_BYTES    = 80;
	localparam int OUTPOINT_BYTES  = 36;
	localparam int VERSION_BYTES   = 4;
	localparam int SEQUENCE_BYTES  = 4;
	localparam int LOCKTIME_BYTES  = 4;
	localparam int VALUE_BYTES     = 8;

	localparam logic [7:0] CS_U16    = 8'hFD;
	localparam logic [7:0] CS_U32    = 8'hFE;
	localparam logic [7:0] SW_MARKER = 8'h00;

	localparam logic REC_TX     = 1'b0;
	localparam logic REC_STATUS = 1'b1;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_SHORT = 2'd1,
		ST_TRUNC = 2'd2
	} status_t;

	typedef enum logic [4:0] {
		PH_HEAD, PH_COUNT, PH_VER, PH_MARK, PH_FLAG, PH_ICOUNT, PH_OUTPT,
		PH_ISLEN, PH_ISCR, PH_ISEQ, PH_OCOUNT, PH_OVAL, PH_OSLEN, PH_OSCR,
		PH_WCOUNT, PH_WLEN, PH_WDATA, PH_LOCK, PH_DONE, PH_ERR
	} phase_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       block_end;
	} in_item_t;

	typedef struct packed {
		logic            record_kind;
		logic [TX_W-1:0] tx_index;
		logic [TX_W-1:0] tx_offset;
		logic [TX_W-1:0] tx_length;
		logic            segwit_flag;
		logic            coinbase_flag;
		logic [1:0]      block_status;
		logic            final_record;
	} result_t;

	// records produced by one accepted byte
	typedef struct packed {
		logic tx_rec;
		logic status_rec;
	} btf_push_t;

endpackage

// File: hdl/block_transaction_framer.sv
// Top level of the block transaction framer: byte parser and result queue.
//
//  channel  | handshake                  | payload                 | beat
//  ---------+----------------------------+-------------------------+--------------------
//  item     | item_valid / item_ready    | item   (in_item_t)      | one block byte
//  result   | result_valid / result_ready| result (result_t)       | one boundary/status
//
// One byte is taken per cycle while item_ready is high; its records enter the queue at
// the same edge and then appear on result, draining one per cycle while result_ready is
// high. A byte that closes a transaction and ends the block yields two records. item_ready
// drops while fewer than two of the four queue slots are free. arst_n clears the parser to
// header phase and empties the queue; a stalled result holds the queue head.
module block_transaction_framer
	import btf_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     item_valid,
	output logic     item_ready,
	input  in_item_t item,
	output logic     result_valid,
	input  logic     result_ready,
	output result_t  result
);

	logic      fire;
	btf_push_t push;
	result_t   rec_tx;
	result_t   rec_stat;
	logic      room;

	assign item_ready = room;
	assign fire       = item_valid & item_ready;

	btf_parser u_parser (
		.clk      (clk),
		.arst_n   (arst_n),
		.fire     (fire),
		.item     (item),
		.push     (push),
		.rec_tx   (rec_tx),
		.rec_stat (rec_stat)
	);

	btf_result_queue u_queue (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.rec_tx       (rec_tx),
		.rec_stat     (rec_stat),
		.room         (room),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	a_end_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		fire && item.block_end |=> result_valid)
		else $error("block end byte produced no record");

	a_status_final: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.record_kind == REC_STATUS |-> result.final_record)
		else $error("status record not marked final");

	a_tx_status_ok: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.record_kind == REC_TX |-> result.block_status == ST_OK)
		else $error("boundary record carries a status");

	a_coinbase: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.record_kind == REC_TX
		|-> result.coinbase_flag == (result.tx_index == '0))
		else $error("coinbase flag disagrees with index");

endmodule

// File: hdl/btf_parser.sv
// Byte-wise parse state machine: walks the block and builds the records for each byte.
module btf_parser
	import btf_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      fire,
	input  in_item_t  item,
	output btf_push_t push,
	output result_t   rec_tx,
	output result_t   rec_stat
);

	phase_t           ph_q, ph_n;
	logic [POS_W-1:0] pos_q, pos_n;
	logic [TX_W-1:0]  start_q, start_n;
	logic [TX_W-1:0]  txl_q, txl_n;
	logic [TX_W-1:0]  cur_q, cur_n;
	logic [TX_W-1:0]  inp_q, inp_n;
	logic [TX_W-1:0]  items_q, items_n;
	logic [TX_W-1:0]  wit_q, wit_n;
	logic [TX_W-1:0]  skip_q, skip_n;
	logic [TX_W-1:0]  vv_q, vv_n;
	logic             vovf_q, vovf_n;
	logic [3:0]       vbl_q, vbl_n;
	logic [2:0]       vsh_q, vsh_n;
	logic             seg_q, seg_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q    <= PH_HEAD;
			pos_q   <= '0;
			start_q <= '0;
			txl_q   <= '0;
			cur_q   <= '0;
			inp_q   <= '0;
			items_q <= '0;
			wit_q   <= '0;
			skip_q  <= '0;
			vv_q    <= '0;
			vovf_q  <= 1'b0;
			vbl_q   <= '0;
			vsh_q   <= '0;
			seg_q   <= 1'b0;
		end else begin
			ph_q    <= ph_n;
			pos_q   <= pos_n;
			start_q <= start_n;
			txl_q   <= txl_n;
			cur_q   <= cur_n;
			inp_q   <= inp_n;
			items_q <= items_n;
			wit_q   <= wit_n;
			skip_q  <= skip_n;
			vv_q    <= vv_n;
			vovf_q  <= vovf_n;
			vbl_q   <= vbl_n;
			vsh_q   <= vsh_n;
			seg_q   <= seg_n;
		end
	end

	always_comb begin
		logic [7:0]      b;
		logic            vstep;
		logic            vdone;
		logic            vovf;
		logic [TX_W-1:0] vval;
		logic [TX_W-1:0] next_at;
		phase_t          eph;
		logic            emit;

		b       = item.data_byte;
		vstep   = 1'b0;
		vdone   = 1'b0;
		vovf    = 1'b0;
		vval    = '0;
		next_at = pos_q[TX_W-1:0] + TX_W'(1);
		eph     = ph_q;
		emit    = 1'b0;

		ph_n    = ph_q;
		pos_n   = pos_q;
		start_n = start_q;
		txl_n   = txl_q;
		cur_n   = cur_q;
		inp_n   = inp_q;
		items_n = items_q;
		wit_n   = wit_q;
		skip_n  = skip_q;
		vv_n    = vv_q;
		vovf_n  = vovf_q;
		vbl_n   = vbl_q;
		vsh_n   = vsh_q;
		seg_n   = seg_q;

		rec_tx               = '0;
		rec_tx.record_kind   = REC_TX;
		rec_tx.tx_index      = cur_q;
		rec_tx.tx_offset     = start_q;
		rec_tx.tx_length     = next_at - start_q;
		rec_tx.segwit_flag   = seg_q;
		rec_tx.coinbase_flag = (cur_q == '0);
		rec_tx.block_status  = ST_OK;
		rec_tx.final_record  = !item.block_end;

		if (fire) begin
			if (pos_q >= POS_W'(MAX_BLOCK_BYTES)) begin
				// out of capacity: stop unless the parse already finished
				if (ph_q != PH_DONE && ph_q != PH_ERR)
					ph_n = PH_ERR;
			end else begin
				pos_n = pos_q + POS_W'(1);
				unique case (ph_q)
					PH_HEAD: begin
						if (pos_q >= POS_W'(HEADER_BYTES - 1))
							ph_n = PH_COUNT;
					end
					PH_DONE, PH_ERR: begin
					end
					PH_FLAG: ph_n = PH_ICOUNT;
					PH_MARK: begin
						if (b == SW_MARKER) begin
							seg_n = 1'b1;
							ph_n  = PH_FLAG;
						end else begin
							ph_n  = PH_ICOUNT;
							eph   = PH_ICOUNT;
							vstep = 1'b1;
						end
					end
					PH_VER, PH_OUTPT, PH_ISCR, PH_ISEQ, PH_OVAL, PH_OSCR, PH_WDATA,
					PH_LOCK: begin
						skip_n = skip_q - TX_W'(1);
						if (skip_q == TX_W'(1)) begin
							unique case (ph_q)
								PH_VER:   ph_n = PH_MARK;
								PH_OUTPT: ph_n = PH_ISLEN;
								PH_ISCR: begin
									ph_n   = PH_ISEQ;
									skip_n = TX_W'(SEQUENCE_BYTES);
								end
								PH_ISEQ: begin
									items_n = items_q - TX_W'(1);
									if (items_q != TX_W'(1)) begin
										ph_n   = PH_OUTPT;
										skip_n = TX_W'(OUTPOINT_BYTES);
									end else begin
										ph_n = PH_OCOUNT;
									end
								end
								PH_OVAL: ph_n = PH_OSLEN;
								PH_OSCR: begin
									items_n = items_q - TX_W'(1);
									if (items_q != TX_W'(1)) begin
										ph_n   = PH_OVAL;
										skip_n = TX_W'(VALUE_BYTES);
									end else if (seg_q && inp_q != '0) begin
										wit_n = inp_q;
										ph_n  = PH_WCOUNT;
									end else begin
										ph_n   = PH_LOCK;
										skip_n = TX_W'(LOCKTIME_BYTES);
									end
								end
								PH_WDATA: begin
									items_n = items_q - TX_W'(1);
									if (items_q != TX_W'(1)) begin
										ph_n = PH_WLEN;
									end else begin
										wit_n = wit_q - TX_W'(1);
										if (wit_q != TX_W'(1)) begin
											ph_n = PH_WCOUNT;
										end else begin
											ph_n   = PH_LOCK;
											skip_n = TX_W'(LOCKTIME_BYTES);
										end
									end
								end
								default: begin
									// lock time done: close the transaction
									emit  = 1'b1;
									cur_n = cur_q + TX_W'(1);
									txl_n = txl_q - TX_W'(1);
									if (txl_q != TX_W'(1)) begin
										start_n = next_at;
										seg_n   = 1'b0;
										ph_n    = PH_VER;
										skip_n  = TX_W'(VERSION_BYTES);
									end else begin
										ph_n = PH_DONE;
									end
								end
							endcase
						end
					end
					default: vstep = 1'b1;
				endcase

				if (vstep) begin
					if (vbl_q == '0) begin
						if (b < CS_U16) begin
							vdone = 1'b1;
							vval  = TX_W'(b);
						end else begin
							vbl_n  = (b == CS_U16) ? 4'd2 : (b == CS_U32) ? 4'd4 : 4'd8;
							vv_n   = '0;
							vovf_n = 1'b0;
							vsh_n  = '0;
						end
					end else begin
						// place the byte; anything at bit 23 or above overflows
						unique case (vsh_q)
							3'd0: vv_n[7:0]  = b;
							3'd1: vv_n[15:8] = b;
							3'd2: begin
								vv_n[TX_W-1:16] = b[TX_W-17:0];
								vovf_n          = vovf_q | b[7];
							end
							default: vovf_n = vovf_q | (b != 8'd0);
						endcase
						vsh_n = vsh_q + 3'd1;
						vbl_n = vbl_q - 4'd1;
						if (vbl_q == 4'd1) begin
							vdone = 1'b1;
							vval  = vv_n;
							vovf  = vovf_n;
						end
					end

					if (vdone) begin
						if (vovf) begin
							ph_n = PH_ERR;
						end else begin
							unique case (eph)
								PH_COUNT: begin
									txl_n = vval;
									if (vval != '0) begin
										start_n = next_at;
										seg_n   = 1'b0;
										ph_n    = PH_VER;
										skip_n  = TX_W'(VERSION_BYTES);
									end else begin
										ph_n = PH_DONE;
									end
								end
								PH_ICOUNT: begin
									inp_n   = vval;
									items_n = vval;
									if (vval != '0) begin
										ph_n   = PH_OUTPT;
										skip_n = TX_W'(OUTPOINT_BYTES);
									end else begin
										ph_n = PH_OCOUNT;
									end
								end
								PH_ISLEN: begin
									skip_n = vval;
									if (vval != '0) begin
										ph_n = PH_ISCR;
									end else begin
										ph_n   = PH_ISEQ;
										skip_n = TX_W'(SEQUENCE_BYTES);
									end
								end
								PH_OCOUNT: begin
									items_n = vval;
									if (vval != '0) begin
										ph_n   = PH_OVAL;
										skip_n = TX_W'(VALUE_BYTES);
									end else if (seg_q && inp_q != '0) begin
										wit_n = inp_q;
										ph_n  = PH_WCOUNT;
									end else begin
										ph_n   = PH_LOCK;
										skip_n = TX_W'(LOCKTIME_BYTES);
									end
								end
								PH_OSLEN: begin
									skip_n = vval;
									if (vval != '0) begin
										ph_n = PH_OSCR;
									end else begin
										items_n = items_q - TX_W'(1);
										if (items_q != TX_W'(1)) begin
											ph_n   = PH_OVAL;
											skip_n = TX_W'(VALUE_BYTES);
										end else if (seg_q && inp_q != '0) begin
											wit_n = inp_q;
											ph_n  = PH_WCOUNT;
										end else begin
											ph_n   = PH_LOCK;
											skip_n = TX_W'(LOCKTIME_BYTES);
										end
									end
								end
								PH_WCOUNT: begin
									items_n = vval;
									if (vval != '0) begin
										ph_n = PH_WLEN;
									end else begin
										wit_n = wit_q - TX_W'(1);
										if (wit_q != TX_W'(1)) begin
											ph_n = PH_WCOUNT;
										end else begin
											ph_n   = PH_LOCK;
											skip_n = TX_W'(LOCKTIME_BYTES);
										end
									end
								end
								default: begin
									// witness item length
									skip_n = vval;
									if (vval != '0) begin
										ph_n = PH_WDATA;
									end else begin
										items_n = items_q - TX_W'(1);
										if (items_q != TX_W'(1)) begin
											ph_n = PH_WLEN;
										end else begin
											wit_n = wit_q - TX_W'(1);
											if (wit_q != TX_W'(1)) begin
												ph_n = PH_WCOUNT;
											end else begin
												ph_n   = PH_LOCK;
												skip_n = TX_W'(LOCKTIME_BYTES);
											end
										end
									end
								end
							endcase
						end
					end
				end
			end
		end

		rec_stat             = '0;
		rec_stat.record_kind = REC_STATUS;
		rec_stat.tx_index    = cur_n;
		rec_stat.final_record = 1'b1;
		if (pos_n < POS_W'(HEADER_BYTES))
			rec_stat.block_status = ST_SHORT;
		else if (ph_n != PH_DONE)
			rec_stat.block_status = ST_TRUNC;
		else
			rec_stat.block_status = ST_OK;

		push.tx_rec     = fire & emit;
		push.status_rec = fire & item.block_end;

		// block end: back to the reset state for the next block
		if (fire && item.block_end) begin
			ph_n    = PH_HEAD;
			pos_n   = '0;
			start_n = '0;
			txl_n   = '0;
			cur_n   = '0;
			inp_n   = '0;
			items_n = '0;
			wit_n   = '0;
			skip_n  = '0;
			vv_n    = '0;
			vovf_n  = 1'b0;
			vbl_n   = '0;
			vsh_n   = '0;
			seg_n   = 1'b0;
		end
	end

endmodule

// File: hdl/btf_result_queue.sv
// Four-entry result queue taking up to two records per cycle, draining one on result_ready.
module btf_result_queue
	import btf_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  btf_push_t push,
	input  result_t   rec_tx,
	input  result_t   rec_stat,
	output logic      room,
	output logic      result_valid,
	input  logic      result_ready,
	output result_t   result
);

	localparam int DEPTH = 4;
	localparam int AW    = $clog2(DEPTH);

	result_t       slot_q [DEPTH];
	logic [AW-1:0] wp_q, rp_q;
	logic [AW:0]   cnt_q;
	logic          pop;
	logic [1:0]    npush;

	assign pop          = result_valid & result_ready;
	assign npush        = {1'b0, push.tx_rec} + {1'b0, push.status_rec};
	assign result_valid = (cnt_q != '0);
	assign result       = slot_q[rp_q];
	// two free slots so a byte that yields two records never stalls mid-beat
	assign room         = (cnt_q <= (AW + 1)'(DEPTH - 2));

	always_ff @(posedge clk) begin
		if (push.tx_rec) begin
			slot_q[wp_q] <= rec_tx;
			if (push.status_rec)
				slot_q[wp_q + AW'(1)] <= rec_stat;
		end else if (push.status_rec) begin
			slot_q[wp_q] <= rec_stat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			wp_q  <= wp_q + AW'(npush);
			rp_q  <= rp_q + AW'(pop);
			cnt_q <= cnt_q + (AW + 1)'(npush) - (AW + 1)'(pop);
		end
	end

endmodule
